// File: rtl/core/brf_pkg.sv
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types, codes and helpers of the byte ring FIFO with claim lock.
// ----------------------------------------------------------------------------
package brf_pkg;

	// Physical depth of the byte store
	localparam int DEPTH = 256;
	localparam int STORE_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Largest usable ring size: store depth, at most the 8-bit index range
	localparam logic [8:0] SIZE_CAP = (DEPTH < 256) ? 9'(DEPTH) : 9'd256;
	localparam logic [8:0] SIZE_RESET = 9'd256;

	// Configuration register byte addresses
	localparam logic [2:0] ADDR_BUFFER_SIZE = 3'd0;

	typedef enum logic [2:0] {
		ACT_READ    = 3'd0,
		ACT_WRITE   = 3'd1,
		ACT_CLAIM   = 3'd2,
		ACT_FILL    = 3'd3,
		ACT_RELEASE = 3'd4
	} action_t;

	// Byte store access for one word
	typedef struct packed {
		logic                wr_en;
		logic                rd_en;
		logic [STORE_AW-1:0] addr;
		logic [7:0]          wdata;
	} mem_req_t;

	// Status of one word, without the popped byte
	typedef struct packed {
		logic       ok;
		logic       is_read;
		logic [7:0] claimed_slot;
		logic       not_empty;
		logic       has_space;
		logic [8:0] fill_level;
	} status_t;

	// Map a ring index onto a store address
	function automatic logic [STORE_AW-1:0] to_addr(input logic [7:0] idx);
		logic [STORE_AW+7:0] wide;
		wide = {{STORE_AW{1'b0}}, idx};
		return wide[STORE_AW-1:0];
	endfunction

	// Step an index by one, wrapping at the ring size
	function automatic logic [7:0] advance(input logic [7:0] idx, input logic [8:0] size);
		logic [8:0] nxt;
		nxt = {1'b0, idx} + 9'd1;
		return (nxt >= size) ? 8'd0 : nxt[7:0];
	endfunction

endpackage

// File: rtl/core/brf_store.sv
// ----------------------------------------------------------------------------
// brf_store
// Byte store: one synchronous write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module brf_store
	import brf_pkg::*;
(
	input  logic       clk,
	input  mem_req_t   req,
	output logic [7:0] rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	// Write on request; hold read data until the next read
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.rd_en) begin
			rdata_q <= mem[req.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/brf_ctrl.sv
// ----------------------------------------------------------------------------
// brf_ctrl
// Ring pointers, fill count and claim lock: decide each word and issue the
// matching byte store access.
// ----------------------------------------------------------------------------
module brf_ctrl
	import brf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [2:0] action,
	input  logic [7:0] data_byte,
	input  logic [7:0] slot_index,
	input  logic [8:0] buffer_size,
	input  logic       cfg_clear,
	output mem_req_t   mem_req,
	output status_t    status
);

	logic [7:0] head_q, tail_q, lock_slot_q;
	logic [8:0] used_q;
	logic       lock_active_q;

	logic [7:0] head_d, tail_d, lock_slot_d, cslot;
	logic [8:0] used_d, size;
	logic       lock_active_d, ok, is_read;

	// Clamp the configured size to the usable range
	always_comb begin
		if (buffer_size == 9'd0) begin
			size = 9'd1;
		end else if (buffer_size > SIZE_CAP) begin
			size = SIZE_CAP;
		end else begin
			size = buffer_size;
		end
	end

	// Decide the word and compute the next pointer state
	always_comb begin
		head_d        = head_q;
		tail_d        = tail_q;
		used_d        = used_q;
		lock_active_d = lock_active_q;
		lock_slot_d   = lock_slot_q;
		ok            = 1'b0;
		is_read       = 1'b0;
		cslot         = 8'd0;
		mem_req.wr_en = 1'b0;
		mem_req.rd_en = 1'b0;
		mem_req.addr  = to_addr(head_q);
		mem_req.wdata = data_byte;
		case (action_t'(action))
			ACT_READ: begin
				if (used_q != 9'd0 && !(lock_active_q && lock_slot_q == tail_q)) begin
					ok            = 1'b1;
					is_read       = 1'b1;
					mem_req.rd_en = take;
					mem_req.addr  = to_addr(tail_q);
					tail_d        = advance(tail_q, size);
					used_d        = used_q - 9'd1;
				end
			end
			ACT_WRITE: begin
				if (used_q < size && !(lock_active_q && lock_slot_q == head_q)) begin
					ok            = 1'b1;
					mem_req.wr_en = take;
					head_d        = advance(head_q, size);
					used_d        = used_q + 9'd1;
				end
			end
			ACT_CLAIM: begin
				if (used_q < size && !(lock_active_q && lock_slot_q == head_q)) begin
					ok    = 1'b1;
					cslot = head_q;
					if (!lock_active_q) begin
						lock_active_d = 1'b1;
						lock_slot_d   = head_q;
					end
					head_d = advance(head_q, size);
					used_d = used_q + 9'd1;
				end
			end
			ACT_FILL: begin
				if ({1'b0, slot_index} < size) begin
					ok            = 1'b1;
					mem_req.wr_en = take;
					mem_req.addr  = to_addr(slot_index);
				end
			end
			ACT_RELEASE: begin
				ok            = 1'b1;
				lock_active_d = 1'b0;
				lock_slot_d   = 8'd0;
			end
			default: begin
			end
		endcase
	end

	// Status seen after the word
	always_comb begin
		status.ok           = ok;
		status.is_read      = is_read;
		status.claimed_slot = cslot;
		status.not_empty    = (used_d != 9'd0);
		status.has_space    = (used_d < size);
		status.fill_level   = used_d;
	end

	// Advance pointer state; a size write empties the ring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q        <= 8'd0;
			tail_q        <= 8'd0;
			used_q        <= 9'd0;
			lock_active_q <= 1'b0;
			lock_slot_q   <= 8'd0;
		end else if (cfg_clear) begin
			head_q        <= 8'd0;
			tail_q        <= 8'd0;
			used_q        <= 9'd0;
			lock_active_q <= 1'b0;
			lock_slot_q   <= 8'd0;
		end else if (take) begin
			head_q        <= head_d;
			tail_q        <= tail_d;
			used_q        <= used_d;
			lock_active_q <= lock_active_d;
			lock_slot_q   <= lock_slot_d;
		end
	end

	// Fill count never exceeds the largest usable ring size
	a_used_cap: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= SIZE_CAP)
		else $error("fill count above capacity");

	// An idle lock carries slot zero
	a_lock_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!lock_active_q |-> lock_slot_q == 8'd0)
		else $error("lock slot set while unlocked");

	// Pointers stay inside the ring
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, head_q} < size) && ({1'b0, tail_q} < size))
		else $error("ring pointer out of range");

	// A popped word lowers the fill count by one
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !cfg_clear && is_read) |=> used_q == $past(used_q) - 9'd1)
		else $error("pop did not lower fill count");

endmodule

// File: rtl/core/brf_outq.sv
// ----------------------------------------------------------------------------
// brf_outq
// Result path: a stage that meets the store read data, then the output
// register that holds a word while the sink stalls.
// ----------------------------------------------------------------------------
module brf_outq
	import brf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  status_t    status,
	input  logic [7:0] mem_rdata,
	output logic       busy,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       ok,
	output logic [7:0] read_data,
	output logic [7:0] claimed_slot,
	output logic       not_empty,
	output logic       has_space,
	output logic [8:0] fill_level
);

	logic    valid_s1;
	status_t status_s1;
	logic    out_valid_q;
	status_t status_q;
	logic [7:0] rdata_q;
	logic    adv;

	// The stage drains whenever the output register is free or leaving
	assign adv  = !out_valid_q || !out_stall;
	assign busy = valid_s1 && !adv;

	// Advance stage and output valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// Hold payload; store read data lands beside the stage
	always_ff @(posedge clk) begin
		if (take) begin
			status_s1 <= status;
		end
		if (adv && valid_s1) begin
			status_q <= status_s1;
			rdata_q  <= status_s1.is_read ? mem_rdata : 8'd0;
		end
	end

	assign out_valid    = out_valid_q;
	assign ok           = status_q.ok;
	assign read_data    = rdata_q;
	assign claimed_slot = status_q.claimed_slot;
	assign not_empty    = status_q.not_empty;
	assign has_space    = status_q.has_space;
	assign fill_level   = status_q.fill_level;

endmodule

// File: rtl/core/byte_ring_fifo_with_claim_lock.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_claim_lock
// Circular byte FIFO with a one-slot claim lock, configuration register port
// and a registered result path.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  action, data_byte, slot_index
//   out      source     out_valid/out_stall  ok, read_data, claimed_slot,
//                                            not_empty, has_space, fill_level
//   cfg      APB slave  psel/penable/pready  buffer_size at byte address 0
//
// One word per cycle while in_stall is low; a taken word passes the stage
// register and then the output register before its result's valid rises.
// The byte store sees at most one access per word, so reads never meet a
// write in flight. The stage in front of the output register stalls the
// input only when both hold a word and the sink stalls. Reset empties the
// ring, drops the lock and sets the size to 256; stored bytes are kept. A
// size write empties the ring the same way.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_claim_lock
	import brf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  slot_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        ok,
	output logic [7:0]  read_data,
	output logic [7:0]  claimed_slot,
	output logic        not_empty,
	output logic        has_space,
	output logic [8:0]  fill_level
);

	logic [8:0] buffer_size_q;
	logic       cfg_wr, take, busy;
	mem_req_t   mem_req;
	status_t    status;
	logic [7:0] mem_rdata;

	// Decode register write
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_BUFFER_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_size_q <= SIZE_RESET;
		end else if (cfg_wr) begin
			buffer_size_q <= pwdata[8:0];
		end
	end

	// Register read back
	assign prdata = (paddr == ADDR_BUFFER_SIZE) ? {23'd0, buffer_size_q} : 32'd0;

	// Accept a word unless the result path is full
	assign in_stall = busy;
	assign take     = in_valid && !busy;

	brf_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.action      (action),
		.data_byte   (data_byte),
		.slot_index  (slot_index),
		.buffer_size (buffer_size_q),
		.cfg_clear   (cfg_wr),
		.mem_req     (mem_req),
		.status      (status)
	);

	brf_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	brf_outq u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.status       (status),
		.mem_rdata    (mem_rdata),
		.busy         (busy),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.ok           (ok),
		.read_data    (read_data),
		.claimed_slot (claimed_slot),
		.not_empty    (not_empty),
		.has_space    (has_space),
		.fill_level   (fill_level)
	);

endmodule

// File: tb/brf_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// brf_checker
// Watches the word channels and the register port of the byte ring FIFO,
// keeps its own copy of ring, lock and size state, predicts the status of
// every accepted word and compares each delivered result in order.
// ----------------------------------------------------------------------------
module brf_checker
	import brf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  action,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  slot_index,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        ok,
	input  logic [7:0]  read_data,
	input  logic [7:0]  claimed_slot,
	input  logic        not_empty,
	input  logic        has_space,
	input  logic [8:0]  fill_level,
	output int          mismatches,
	output int          words_pending
);

	typedef struct packed {
		logic       ok;
		logic [7:0] popped;
		logic [7:0] slot;
		logic       not_empty;
		logic       has_space;
		logic [8:0] level;
	} word_status_t;

	// Shadow of the ring
	logic [7:0]   shadow_bytes [0:255];
	logic [7:0]   head;
	logic [7:0]   tail;
	logic [8:0]   used;
	logic         lock_on;
	logic [7:0]   lock_at;
	logic [8:0]   size_reg;
	word_status_t awaited [$];
	int           miss_count;

	// Clamp the size register into the usable range
	function automatic logic [8:0] ring_span(input logic [8:0] s);
		if (s == 9'd0)
			return 9'd1;
		if (s > SIZE_CAP)
			return SIZE_CAP;
		return s;
	endfunction

	// Step a ring position, wrapping after the last slot
	function automatic logic [7:0] next_slot(input logic [7:0] idx, input logic [8:0] span);
		return ({1'b0, idx} == span - 9'd1) ? 8'd0 : idx + 8'd1;
	endfunction

	// Apply one word to the shadow state and work out its status
	task automatic predict_word(input logic [2:0] code, input logic [7:0] din,
			input logic [7:0] at, output word_status_t res);
		logic [8:0] span;
		span = ring_span(size_reg);
		res = '0;
		case (code)
			ACT_READ: begin
				if (used != 9'd0 && !(lock_on && lock_at == tail)) begin
					res.popped = shadow_bytes[tail];
					tail = next_slot(tail, span);
					used = used - 9'd1;
					res.ok = 1'b1;
				end
			end
			ACT_WRITE: begin
				if (used < span && !(lock_on && lock_at == head)) begin
					shadow_bytes[head] = din;
					head = next_slot(head, span);
					used = used + 9'd1;
					res.ok = 1'b1;
				end
			end
			ACT_CLAIM: begin
				if (used < span && !(lock_on && lock_at == head)) begin
					res.slot = head;
					// only the first claim takes the lock
					if (!lock_on) begin
						lock_on = 1'b1;
						lock_at = head;
					end
					head = next_slot(head, span);
					used = used + 9'd1;
					res.ok = 1'b1;
				end
			end
			ACT_FILL: begin
				if ({1'b0, at} < span) begin
					shadow_bytes[at] = din;
					res.ok = 1'b1;
				end
			end
			ACT_RELEASE: begin
				lock_on = 1'b0;
				lock_at = 8'd0;
				res.ok = 1'b1;
			end
			default: begin
			end
		endcase
		res.not_empty = (used != 9'd0);
		res.has_space = (used < span);
		res.level = used;
	endtask

	// Drop all ring state back to empty; stored bytes stay
	task automatic empty_ring();
		head = 8'd0;
		tail = 8'd0;
		used = 9'd0;
		lock_on = 1'b0;
		lock_at = 8'd0;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		word_status_t want;
		word_status_t got;
		if (!arst_n) begin
			empty_ring();
			size_reg = SIZE_RESET;
			awaited.delete();
			miss_count = 0;
			mismatches <= 0;
			words_pending <= 0;
		end else begin
			// Compare a delivered result against the oldest prediction
			if (out_valid && !out_stall) begin
				got = {ok, read_data, claimed_slot, not_empty, has_space, fill_level};
				if (awaited.size() == 0) begin
					miss_count++;
					if (miss_count <= 10)
						$display("%0t: result word with nothing awaited: ok=%0b rd=%02h slot=%02h",
							$realtime, ok, read_data, claimed_slot);
				end else begin
					want = awaited.pop_front();
					if (got !== want) begin
						miss_count++;
						if (miss_count <= 10)
							$display({"%0t: status mismatch exp ok=%0b rd=%02h slot=%02h ne=%0b hs=%0b lvl=%0d",
								" | got ok=%0b rd=%02h slot=%02h ne=%0b hs=%0b lvl=%0d"},
								$realtime, want.ok, want.popped, want.slot, want.not_empty,
								want.has_space, want.level, got.ok, got.popped, got.slot,
								got.not_empty, got.has_space, got.level);
					end
				end
			end
			// Size write resets the ring; other addresses hold nothing
			if (psel && penable && pwrite && pready && paddr == ADDR_BUFFER_SIZE) begin
				size_reg = pwdata[8:0];
				empty_ring();
			end
			// Predict each accepted word
			if (in_valid && !in_stall) begin
				predict_word(action, data_byte, slot_index, want);
				awaited.push_back(want);
			end
			words_pending <= awaited.size();
			mismatches <= miss_count;
		end
	end

endmodule

// File: tb/tb_byte_ring_fifo_with_claim_lock.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_byte_ring_fifo_with_claim_lock
// Drives the byte ring FIFO with a preload of every store slot, a directed
// pass over refusals and locks, then random word phases at several ring
// sizes, clamped ones included, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_byte_ring_fifo_with_claim_lock;
	import brf_pkg::*;

	localparam int         CYCLE_LIMIT   = 400000;
	localparam logic [2:0] ADDR_SPARE    = 3'd4;
	localparam int         PHASE_COUNT   = 10;
	localparam int         MODE_MIXED    = 0;
	localparam int         MODE_FILLING  = 1;
	localparam int         MODE_DRAINING = 2;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        psel       = 1'b0;
	logic        penable    = 1'b0;
	logic        pwrite     = 1'b0;
	logic [2:0]  paddr      = 3'd0;
	logic [31:0] pwdata     = 32'd0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid   = 1'b0;
	logic        in_stall;
	logic [2:0]  action     = 3'd0;
	logic [7:0]  data_byte  = 8'd0;
	logic [7:0]  slot_index = 8'd0;
	logic        out_valid;
	logic        out_stall  = 1'b0;
	logic        ok;
	logic [7:0]  read_data;
	logic [7:0]  claimed_slot;
	logic        not_empty;
	logic        has_space;
	logic [8:0]  fill_level;

	int          mismatch_total;
	int          expected_left;
	int unsigned cycle_count = 0;
	int          stall_left  = 0;
	logic        calm        = 1'b0;
	int          span_now    = 256;

	byte_ring_fifo_with_claim_lock dut (.*);

	brf_checker ring_check (
		.mismatches   (mismatch_total),
		.words_pending(expected_left),
		.*
	);

	initial forever #5 clk = ~clk;

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Stall the result side in short bursts and a few long ones
	always @(posedge clk or negedge arst_n) begin : sink_stall
		int r;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else if (calm) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				out_stall <= 1'b0;
			end else if (r < 95) begin
				out_stall <= 1'b1;
				stall_left = $urandom_range(0, 3);
			end else begin
				out_stall <= 1'b1;
				stall_left = $urandom_range(10, 40);
			end
		end
	end

	// Offer one word after a random gap and hold it until taken
	task automatic send_word(input logic [2:0] code, input logic [7:0] din, input logic [7:0] at);
		int gap;
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			gap = 0;
		else if (r < 92)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 30);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= code;
		data_byte <= din;
		slot_index <= at;
		do @(posedge clk); while (in_stall);
	endtask

	// Register write: setup phase, then access phase until pready
	task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Wait until every predicted status has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_left != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write the ring size while idle and track the clamped span
	task automatic set_size(input logic [8:0] sz);
		wait_drained();
		apb_write(ADDR_BUFFER_SIZE, {23'($urandom), sz});
		span_now = (sz == 9'd0) ? 1 : (sz > SIZE_CAP) ? int'(SIZE_CAP) : int'(sz);
	endtask

	initial begin : stimulus
		int         cut [3][5];
		int         mode;
		int         chunk;
		int         words;
		int         r;
		logic [8:0] sz;
		logic [2:0] code;
		logic [7:0] at;

		cut = '{'{30, 60, 70, 85, 95}, '{10, 60, 72, 84, 95}, '{60, 75, 80, 88, 97}};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Preload every store slot so no read can pop an unwritten byte
		for (int i = 0; i < 256; i++)
			send_word(ACT_FILL, 8'($urandom), 8'(i));

		// Directed: empty, extremes, claim lock, releases, bad codes
		send_word(ACT_READ, 8'h00, 8'h00);
		send_word(ACT_WRITE, 8'h00, 8'h00);
		send_word(ACT_WRITE, 8'hFF, 8'hFF);
		send_word(ACT_READ, 8'h00, 8'h00);
		send_word(ACT_READ, 8'h00, 8'h00);
		send_word(ACT_CLAIM, 8'h00, 8'h00);
		send_word(ACT_CLAIM, 8'h00, 8'h00);
		send_word(ACT_FILL, 8'hA5, 8'd2);
		send_word(ACT_READ, 8'h00, 8'h00);
		send_word(ACT_WRITE, 8'h81, 8'h00);
		send_word(ACT_RELEASE, 8'h00, 8'h00);
		send_word(ACT_RELEASE, 8'h00, 8'h00);
		send_word(ACT_READ, 8'h00, 8'h00);
		send_word(ACT_READ, 8'h00, 8'h00);
		send_word(ACT_READ, 8'h00, 8'h00);
		send_word(3'(ACT_RELEASE) + 3'd1, 8'hFF, 8'hFF);
		send_word(3'(ACT_RELEASE) + 3'd3, 8'hFF, 8'hFF);
		send_word(ACT_FILL, 8'h5A, 8'hFF);

		// Directed: single-slot ring, full and locked at once
		set_size(9'd1);
		send_word(ACT_WRITE, 8'h3C, 8'h00);
		send_word(ACT_WRITE, 8'hC3, 8'h00);
		send_word(ACT_CLAIM, 8'h00, 8'h00);
		send_word(ACT_FILL, 8'h77, 8'd1);
		send_word(ACT_FILL, 8'h66, 8'd0);
		send_word(ACT_READ, 8'h00, 8'h00);
		send_word(ACT_CLAIM, 8'h00, 8'h00);
		send_word(ACT_READ, 8'h00, 8'h00);
		send_word(ACT_RELEASE, 8'h00, 8'h00);
		send_word(ACT_READ, 8'h00, 8'h00);

		// Random phases over a spread of sizes, clamped ones included
		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0: sz = 9'd2;
				1: sz = 9'd256;
				2: sz = 9'd3;
				3: sz = 9'd0;
				4: sz = 9'd511;
				5: sz = 9'($urandom_range(4, 16));
				6: sz = 9'd257;
				7: sz = 9'($urandom_range(1, 256));
				8: sz = 9'd255;
				default: sz = 9'($urandom_range(1, 8));
			endcase
			set_size(sz);
			// a write to an unmapped address must change nothing
			if (p == 5)
				apb_write(ADDR_SPARE, $urandom());
			calm = ($urandom_range(0, 3) == 0);
			words = (span_now >= 128) ? 180 : 100;
			chunk = 0;
			mode = MODE_MIXED;
			for (int n = 0; n < words; n++) begin
				// switch between filling, draining and mixed stretches
				if (chunk == 0) begin
					mode = $urandom_range(0, 2);
					chunk = $urandom_range(20, 150);
				end
				chunk--;
				r = $urandom_range(0, 99);
				if (r < cut[mode][0])
					code = ACT_READ;
				else if (r < cut[mode][1])
					code = ACT_WRITE;
				else if (r < cut[mode][2])
					code = ACT_CLAIM;
				else if (r < cut[mode][3])
					code = ACT_FILL;
				else if (r < cut[mode][4])
					code = ACT_RELEASE;
				else
					code = 3'(ACT_RELEASE) + 3'($urandom_range(1, 3));
				if ($urandom_range(0, 4) != 0)
					at = 8'($urandom_range(0, span_now - 1));
				else
					at = 8'($urandom_range(0, 255));
				send_word(code, 8'($urandom), at);
			end
		end

		calm = 1'b0;
		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatch_total == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
